FILE: hw/rtl/mexp_pkg.sv
package mexp_pkg;

  // Prime modulus and the width of a fully reduced residue.
  localparam int unsigned WORD_W = 30;
  localparam logic [WORD_W-1:0] PRIME = 30'd1000000007;

  // Each cell consumes one radix-4 digit of the multiplier operand.
  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned NCELL = WORD_W / DIGIT_W;

  // Three times a residue needs 32 bits; a cell's partial sum stays below 7P.
  localparam int unsigned A3_W = 32;
  localparam int unsigned SUM_W = 33;

  // Base input width, and the number of chain passes that reduce it.
  localparam int unsigned BASE_W = 63;
  localparam int unsigned RED_PASSES = 3;
  localparam int unsigned RED_W = RED_PASSES * WORD_W;

  // Multiples of the prime used by the quotient selection in each cell.
  localparam int unsigned QMAX = 6;
  localparam logic [SUM_W-1:0] MULT_P [0:QMAX] = '{
    33'd0,
    33'd1000000007,
    33'd2000000014,
    33'd3000000021,
    33'd4000000028,
    33'd5000000035,
    33'd6000000042
  };

  // Job carried by a token through the chain.
  typedef enum logic [1:0] {
    TK_RED = 2'd0,
    TK_SQR = 2'd1,
    TK_MUL = 2'd2
  } tok_kind_t;

  // One token: running remainder, multiplicand (and its triple), and the
  // multiplier digits still to be consumed, most significant first.
  typedef struct packed {
    logic              valid;
    tok_kind_t         kind;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] a;
    logic [A3_W-1:0]   a3;
    logic [WORD_W-1:0] b;
  } token_t;

endpackage

FILE: hw/rtl/modular_exponentiation_top.sv
// Channel   Direction  Signals                      Handshake
// request   in         base[62:0], exponent[62:0]   beat taken when start && !busy
// result    out        power_mod[29:0]              one-cycle beat marked by done
//
// A modular multiply runs through a row of 15 radix-4 cells, one cell per
// cycle. Base reduction takes 3 passes of the chain, each issued after the
// last has left it; each exponent bit then costs one pass (square and multiply
// share the chain when the bit is set), up to the highest set bit.
// Reset is synchronous and returns the block to idle with an empty chain.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module modular_exponentiation_top #(
  parameter int EXPONENT_BITS = 63
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mexp_pkg::BASE_W-1:0]     base,
  input  logic [62:0]                     exponent,
  output logic                            done,
  output logic [mexp_pkg::WORD_W-1:0]     power_mod
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_RED_ISSUE = 7'b0000010,
    ST_RED_WAIT  = 7'b0000100,
    ST_SQR_ISSUE = 7'b0001000,
    ST_MUL_ISSUE = 7'b0010000,
    ST_WAIT      = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t                          state;
  logic [EXPONENT_BITS-1:0]        e;
  logic [EXPONENT_BITS-1:0]        e_shr;
  logic [mexp_pkg::RED_W-1:0]      red_word;
  logic [1:0]                      red_left;
  logic [mexp_pkg::WORD_W-1:0]     bcur;
  logic [mexp_pkg::WORD_W-1:0]     acc;

  mexp_pkg::token_t                tok [0:mexp_pkg::NCELL];
  mexp_pkg::token_t                tok_last;
  logic [mexp_pkg::WORD_W-1:0]     feed_a;

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);
  assign power_mod = acc;
  assign e_shr     = e >> 1;
  assign tok_last  = tok[mexp_pkg::NCELL];

  // Token fed into the first cell.
  always_comb begin
    tok[0] = '0;
    feed_a = '0;
    unique case (state)
      ST_RED_ISSUE: begin
        feed_a       = mexp_pkg::WORD_W'(1);
        tok[0].valid = 1'b1;
        tok[0].kind  = mexp_pkg::TK_RED;
        tok[0].r     = bcur;
        tok[0].b     = red_word[mexp_pkg::RED_W-1 -: mexp_pkg::WORD_W];
      end
      ST_SQR_ISSUE: begin
        feed_a       = bcur;
        tok[0].valid = 1'b1;
        tok[0].kind  = mexp_pkg::TK_SQR;
        tok[0].b     = bcur;
      end
      ST_MUL_ISSUE: begin
        feed_a       = acc;
        tok[0].valid = 1'b1;
        tok[0].kind  = mexp_pkg::TK_MUL;
        tok[0].b     = bcur;
      end
      default: begin
        feed_a = '0;
      end
    endcase
    tok[0].a  = feed_a;
    tok[0].a3 = {2'b00, feed_a} + {1'b0, feed_a, 1'b0};
  end

  // Row of reduction cells.
  for (genvar i = 0; i < mexp_pkg::NCELL; i++) begin : g_cell
    mexp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Sequencer: base reduction passes, then one square (and multiply) per bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RED_ISSUE;
          end
        end
        ST_RED_ISSUE: begin
          state <= ST_RED_WAIT;
        end
        ST_RED_WAIT: begin
          if (tok_last.valid) begin
            if (red_left != 2'd1) begin
              state <= ST_RED_ISSUE;
            end else if (e == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SQR_ISSUE;
            end
          end
        end
        ST_SQR_ISSUE: begin
          state <= e[0] ? ST_MUL_ISSUE : ST_WAIT;
        end
        ST_MUL_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (tok_last.valid &&
              ((tok_last.kind == mexp_pkg::TK_MUL) || !e[0])) begin
            state <= (e_shr == '0) ? ST_DONE : ST_SQR_ISSUE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working values; none of them needs a reset.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      e        <= exponent[EXPONENT_BITS-1:0];
      red_word <= {{(mexp_pkg::RED_W-mexp_pkg::BASE_W){1'b0}}, base};
      red_left <= 2'(mexp_pkg::RED_PASSES);
      bcur     <= '0;
      acc      <= mexp_pkg::WORD_W'(1);
    end else if ((state == ST_RED_WAIT) && tok_last.valid) begin
      bcur     <= tok_last.r;
      red_word <= red_word << mexp_pkg::WORD_W;
      red_left <= red_left - 2'd1;
    end else if ((state == ST_WAIT) && tok_last.valid) begin
      if (tok_last.kind == mexp_pkg::TK_SQR) begin
        bcur <= tok_last.r;
      end else begin
        acc <= tok_last.r;
      end
      if ((tok_last.kind == mexp_pkg::TK_MUL) || !e[0]) begin
        e <= e_shr;
      end
    end
  end

  // A token only leaves the chain while the sequencer waits for it.
  a_tok_expected: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> ((state == ST_RED_WAIT) || (state == ST_WAIT)))
    else $error("token left the chain while none was expected");

  // The result is always a fully reduced residue.
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (power_mod < mexp_pkg::PRIME))
    else $error("result not reduced below the prime");

  // An accepted beat makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat did not start the sequencer");

  // The result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

FILE: hw/rtl/mexp_cell.sv
module mexp_cell (
  input  logic               clk,
  input  logic               rst,
  input  mexp_pkg::token_t   tok_in,
  output mexp_pkg::token_t   tok_out
);

  logic [mexp_pkg::DIGIT_W-1:0] digit;
  logic [mexp_pkg::SUM_W-1:0]   addend;
  logic [mexp_pkg::SUM_W-1:0]   sum;
  logic [2:0]                   q;
  logic [mexp_pkg::SUM_W-1:0]   diff;

  logic                         valid;
  mexp_pkg::tok_kind_t          kind;
  logic [mexp_pkg::WORD_W-1:0]  r;
  logic [mexp_pkg::WORD_W-1:0]  a;
  logic [mexp_pkg::A3_W-1:0]    a3;
  logic [mexp_pkg::WORD_W-1:0]  b;

  // Select the digit multiple of the multiplicand.
  always_comb begin
    digit = tok_in.b[mexp_pkg::WORD_W-1 -: mexp_pkg::DIGIT_W];
    case (digit)
      2'd0:    addend = '0;
      2'd1:    addend = {3'b000, tok_in.a};
      2'd2:    addend = {2'b00, tok_in.a, 1'b0};
      default: addend = {1'b0, tok_in.a3};
    endcase
  end

  // Shift in one radix-4 digit: 4r + d*a stays below 7P.
  assign sum = {1'b0, tok_in.r, 2'b00} + addend;

  // Pick the largest multiple of P not above the sum and take it off.
  always_comb begin
    q = '0;
    for (int k = 1; k <= int'(mexp_pkg::QMAX); k++) begin
      if (sum >= mexp_pkg::MULT_P[k]) begin
        q = 3'(k);
      end
    end
    diff = sum - mexp_pkg::MULT_P[q];
  end

  // Token register: only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    kind <= tok_in.kind;
    r    <= diff[mexp_pkg::WORD_W-1:0];
    a    <= tok_in.a;
    a3   <= tok_in.a3;
    b    <= {tok_in.b[mexp_pkg::WORD_W-mexp_pkg::DIGIT_W-1:0], {mexp_pkg::DIGIT_W{1'b0}}};
  end

  always_comb begin
    tok_out.valid = valid;
    tok_out.kind  = kind;
    tok_out.r     = r;
    tok_out.a     = a;
    tok_out.a3    = a3;
    tok_out.b     = b;
  end

endmodule
